// ----- design/mfcd_pkg.sv -----
`default_nettype none

package mfcd_pkg;

  localparam int unsigned FRAME_W      = 32;
  localparam int unsigned PREAMBLE_LEN = 18;
  localparam int unsigned CHAR_W       = 7;
  localparam int unsigned CNT_W        = 6;   // holds 0..32
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;

  // Preamble bit k is compared with line bit (rot + k): 0101...01 then 10.
  localparam logic [PREAMBLE_LEN-1:0] PREAMBLE = 18'h1AAAA;

  localparam logic [CNT_W-1:0] ONES_REQUIRED_RST = 6'd16;

  // Register word index (paddr[2]).
  localparam logic REG_ONES_REQUIRED = 1'b0;

  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef struct packed {
    char_t dec_char;
    logic  balanced;
    logic  found;
  } mfcd_res_t;

endpackage

`default_nettype wire

// ----- design/mfcd_search.sv -----
`default_nettype none

module mfcd_search (
  input  mfcd_pkg::frame_t    frame,
  input  mfcd_pkg::cnt_t      ones_required,
  output mfcd_pkg::mfcd_res_t res
);

  logic [2*mfcd_pkg::FRAME_W-1:0] dbl;
  mfcd_pkg::frame_t               win;
  mfcd_pkg::cnt_t                 ones;
  mfcd_pkg::char_t                cand;
  mfcd_pkg::char_t                sel_char;
  logic                           any_match;

  assign dbl = {frame, frame};

  // Balance check: population count of the frame.
  always_comb begin
    ones = '0;
    for (int i = 0; i < mfcd_pkg::FRAME_W; i++) begin
      ones = ones + mfcd_pkg::cnt_t'(frame[i]);
    end
  end

  // All rotations in parallel; a later (higher) rotation overrides.
  always_comb begin
    any_match = 1'b0;
    sel_char  = '0;
    win       = '0;
    cand      = '0;
    for (int r = 0; r < mfcd_pkg::FRAME_W; r++) begin
      win = dbl[r +: mfcd_pkg::FRAME_W];
      for (int y = 0; y < mfcd_pkg::CHAR_W; y++) begin
        cand[y] = !win[mfcd_pkg::PREAMBLE_LEN + 2*y] && win[mfcd_pkg::PREAMBLE_LEN + 2*y + 1];
      end
      if (win[mfcd_pkg::PREAMBLE_LEN-1:0] == mfcd_pkg::PREAMBLE) begin
        any_match = 1'b1;
        sel_char  = cand;
      end
    end
  end

  always_comb begin
    res.balanced = (ones == ones_required);
    res.found    = res.balanced && any_match;
    res.dec_char = sel_char;
  end

endmodule

`default_nettype wire

// ----- design/manchester_frame_char_decoder_top.sv -----
// Manchester frame character decoder.
// Input channel (in_valid / in_stall / in_frame_bits): one 32-bit circular
// frame per item, line bit i = bit i%8 of received byte i/8.
// Result channel (out_valid / out_stall / out_*): one item per frame with the
// decoded character, the balance flag and the preamble flag.
// A frame is decoded only if its ones count equals ones_required; then the
// 18-bit preamble is searched at all 32 rotations (highest match wins) and
// the 7 following bit pairs give the character (pair 01 -> 1). If the count
// differs or no rotation matches, the last good character is repeated.
// An accepted item lands in the input register, then in the result register.
// Throughput: one item per cycle unless out_stall holds the result; popcount,
// rotation compares and pair decode are one combinational pass between the
// two registers.
// Reset (rst_n low, synchronous): both stages empty, last character 0,
// ones_required 16.
// Stall: a stalled result holds; the input register still takes an item
// while the result register is full, and in_stall rises only when both
// stages are held.
// Config: APB, ones_required at byte address 0; write only while idle.
`default_nettype none

module manchester_frame_char_decoder_top (
  input  wire                                      clk,
  input  wire                                      rst_n,
  // input channel
  input  wire                                      in_valid,
  output logic                                     in_stall,
  input  wire  [mfcd_pkg::FRAME_W-1:0]             in_frame_bits,
  // result channel
  output logic                                     out_valid,
  input  wire                                      out_stall,
  output logic [mfcd_pkg::CHAR_W-1:0]              out_character,
  output logic                                     out_balanced,
  output logic                                     out_preamble_found,
  // configuration
  input  wire                                      cfg_psel,
  input  wire                                      cfg_penable,
  input  wire                                      cfg_pwrite,
  input  wire  [mfcd_pkg::CFG_ADDR_W-1:0]          cfg_paddr,
  input  wire  [mfcd_pkg::CFG_DATA_W-1:0]          cfg_pwdata,
  output logic [mfcd_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                     cfg_pready
);

  // config register
  mfcd_pkg::cnt_t ones_req_r;
  logic           cfg_wr;

  // input stage
  logic             s1_valid_r;
  mfcd_pkg::frame_t frame_r;

  // result stage and decoder state
  logic            out_valid_r;
  mfcd_pkg::char_t out_char_r;
  logic            out_bal_r;
  logic            out_found_r;
  mfcd_pkg::char_t last_char_r;
  mfcd_pkg::char_t char_nxt;

  mfcd_pkg::mfcd_res_t res;
  logic                out_ready;
  logic                in_take;

  //--------------------------------------------------------------------------
  // APB register
  //--------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite
                      && (cfg_paddr[2] == mfcd_pkg::REG_ONES_REQUIRED);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == mfcd_pkg::REG_ONES_REQUIRED) begin
      cfg_prdata = mfcd_pkg::CFG_DATA_W'(ones_req_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_req_r <= mfcd_pkg::ONES_REQUIRED_RST;
    end else if (cfg_wr) begin
      ones_req_r <= cfg_pwdata[mfcd_pkg::CNT_W-1:0];
    end
  end

  //--------------------------------------------------------------------------
  // Handshake: result register frees when empty or taken
  //--------------------------------------------------------------------------
  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      frame_r <= in_frame_bits;
    end
  end

  //--------------------------------------------------------------------------
  // Decode between input and result registers
  //--------------------------------------------------------------------------
  mfcd_search u_search (
    .frame         (frame_r),
    .ones_required (ones_req_r),
    .res           (res)
  );

  // failed decode repeats the last good character
  assign char_nxt = res.found ? res.dec_char : last_char_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_char_r <= '0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        last_char_r <= char_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid_r) begin
      out_char_r  <= char_nxt;
      out_bal_r   <= res.balanced;
      out_found_r <= res.found;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_character      = out_char_r;
  assign out_balanced       = out_bal_r;
  assign out_preamble_found = out_found_r;

endmodule

`default_nettype wire

// ----- design/mfcd_checker.sv -----
`default_nettype none

module mfcd_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_stall,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire [mfcd_pkg::CHAR_W-1:0]       out_character,
  input wire                              out_balanced,
  input wire                              out_preamble_found,
  input wire                              cfg_pready
);

  // empty result register after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_character)
      && $stable(out_balanced) && $stable(out_preamble_found))
    else $error("stalled result changed");

  // preamble is only reported for a balanced frame
  a_found_bal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_preamble_found |-> out_balanced)
    else $error("preamble flagged on unbalanced frame");

  // input backpressure only when the full result is held
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  // the register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("pready low");

endmodule

bind manchester_frame_char_decoder_top mfcd_checker u_mfcd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_character      (out_character),
  .out_balanced       (out_balanced),
  .out_preamble_found (out_preamble_found),
  .cfg_pready         (cfg_pready)
);

`default_nettype wire
